// ===== rtl/wttd_pkg.sv =====
// Shared types, constants and helper functions of the waypoint controller.
`default_nettype none

package wttd_pkg;

  localparam int HEAD_W     = 16;
  localparam int DEG_W      = 9;
  localparam int LIN_W      = 10;
  localparam int ANG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int GUARD      = 4;
  localparam int ATAN_LEN   = 20;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W     = 16;
  localparam int ZW         = 21;
  localparam int BRG_W      = ZW - 3;
  localparam int CMP_W      = 20;
  localparam int MAG_W      = 15;

  localparam logic signed [ZW-1:0]    PI_Q16         = 21'sd205887;
  localparam logic signed [CMP_W-1:0] PI_Q13         = 20'sd25736;
  localparam logic [23:0]             DEG_TO_Q13_Q16 = 24'd9370164;
  localparam logic [15:0]             INV_GAIN_Q16   = 16'd39797;
  localparam logic [13:0]             TURN_CAP       = 14'd8192;

  localparam logic [12:0] HEADING_TOL_RST = 13'd82;
  localparam logic [11:0] ARRIVE_DIST_RST = 12'd20;
  localparam logic [9:0]  LINEAR_MIN_RST  = 10'd102;
  localparam logic [9:0]  LINEAR_MAX_RST  = 10'd307;
  localparam logic [13:0] STEER_RATE_RST  = 14'd1638;
  localparam logic [13:0] TURN_MIN_RST    = 14'd819;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADING_TOL = 3'd0,
    CFG_ARRIVE_DIST = 3'd1,
    CFG_LINEAR_MIN  = 3'd2,
    CFG_LINEAR_MAX  = 3'd3,
    CFG_STEER_RATE  = 3'd4,
    CFG_TURN_MIN    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TURN  = 2'd1,
    PH_DRIVE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GOAL,
    S_EVAL,
    S_CORDIC,
    S_MUL_LO,
    S_MUL_HI,
    S_DRIVE,
    S_HOLD
  } seq_e;

  typedef struct packed {
    logic [12:0] heading_tol;
    logic [11:0] arrive_dist;
    logic [9:0]  linear_min;
    logic [9:0]  linear_max;
    logic [13:0] steer_rate;
    logic [13:0] turn_min;
  } cfg_t;

  typedef struct packed {
    logic [LIN_W-1:0]        linear_cmd;
    logic signed [ANG_W-1:0] angular_cmd;
    logic                    arrived;
    phase_e                  phase_out;
  } res_t;

  // Arctangent of 2^-i in 1/65536 rad.
  function automatic logic [ATAN_W-1:0] atan_q16(logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Pick the turn direction by the half-circle rule around target angle t.
  function automatic logic signed [ANG_W-1:0] signed_cmd(
    logic signed [BRG_W-1:0]  t,
    logic signed [HEAD_W-1:0] th,
    logic [MAG_W-1:0]         mag
  );
    logic signed [CMP_W-1:0] tw;
    logic signed [CMP_W-1:0] thw;
    logic signed [ANG_W-1:0] pos;
    logic                    use_pos;
    tw  = $signed({{(CMP_W-BRG_W){t[BRG_W-1]}}, t});
    thw = $signed({{(CMP_W-HEAD_W){th[HEAD_W-1]}}, th});
    pos = $signed({1'b0, mag});
    if (!tw[CMP_W-1]) begin
      use_pos = (thw <= tw) && (thw >= tw - PI_Q13);
    end else begin
      use_pos = !((thw <= tw + PI_Q13) && (thw > tw));
    end
    return use_pos ? pos : -pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/wttd_if.sv =====
// Handshake channel interfaces: pose input, command output and register writes.
`default_nettype none

interface wttd_in_if #(
  parameter int POS_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic                                start_req;
  logic signed [POS_WIDTH-1:0]         pos_x;
  logic signed [POS_WIDTH-1:0]         pos_y;
  logic signed [wttd_pkg::HEAD_W-1:0]  heading;
  logic signed [POS_WIDTH-1:0]         target_x;
  logic signed [POS_WIDTH-1:0]         target_y;
  logic signed [wttd_pkg::DEG_W-1:0]   target_deg;

  modport source (
    output valid, start_req, pos_x, pos_y, heading, target_x, target_y, target_deg,
    input  ready
  );
  modport sink (
    input  valid, start_req, pos_x, pos_y, heading, target_x, target_y, target_deg,
    output ready
  );
endinterface

interface wttd_out_if;
  logic                               valid;
  logic                               ready;
  logic [wttd_pkg::LIN_W-1:0]         linear_cmd;
  logic signed [wttd_pkg::ANG_W-1:0]  angular_cmd;
  logic                               arrived;
  logic [1:0]                         phase_out;

  modport source (
    output valid, linear_cmd, angular_cmd, arrived, phase_out,
    input  ready
  );
  modport sink (
    input  valid, linear_cmd, angular_cmd, arrived, phase_out,
    output ready
  );
endinterface

interface wttd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wttd_pkg::CFG_IDX_W-1:0]      index;
  logic [wttd_pkg::CFG_DATA_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/waypoint_turn_then_drive_controller.sv =====
// Waypoint turn-then-drive controller: sequencer, goal latch and command output.
// Usage:
//   in_if carries one pose sample per control tick; start_req = 1 latches a new goal
//   (target_x, target_y, target_deg) and enters the turning phase on the same sample.
//   out_if returns exactly one command per sample: linear_cmd, angular_cmd, arrived
//   and phase_out (0 idle, 1 turning, 2 driving). cfg_if writes the six limit
//   registers by index; it is always ready and should be used while the block is idle.
// Timing:
//   A sample handled in the idle or turning phase passes the states S_GOAL, S_EVAL and
//   S_HOLD, where it loads the output register; the next sample is taken in S_IDLE.
//   A sample in the driving phase runs the iterative CORDIC, one micro-rotation per
//   cycle, then a two-step constant multiply (S_MUL_LO, S_MUL_HI), then S_DRIVE, S_HOLD.
//   One sample is in work at a time; in_if.ready is high only between samples.
// Reset: phase goes idle, the goal clears, registers take their default values.
// Stall: a result waits in the output register while out_if.ready is low; the
//   following result waits in the sequencer until the register frees up.
`default_nettype none

module waypoint_turn_then_drive_controller #(
  parameter int CORDIC_ITERATIONS = 14,
  parameter int POS_WIDTH         = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wttd_in_if.sink     in_if,
  wttd_out_if.source  out_if,
  wttd_cfg_if.sink    cfg_if
);

  localparam int GUARD  = wttd_pkg::GUARD;
  localparam int HW_    = wttd_pkg::HEAD_W;
  localparam int DEG_W  = wttd_pkg::DEG_W;
  localparam int ZW     = wttd_pkg::ZW;
  localparam int BRG_W  = wttd_pkg::BRG_W;
  localparam int MAG_W  = wttd_pkg::MAG_W;
  localparam int LIN_W  = wttd_pkg::LIN_W;
  localparam int XW     = POS_WIDTH + 7;
  localparam int ACC_W  = XW + 16;
  localparam int DIST_W = XW - GUARD;

  wttd_pkg::seq_e   state_q, state_d;
  wttd_pkg::phase_e phase_q, phase_d;
  wttd_pkg::cfg_t   cfg;
  wttd_pkg::res_t   res_q, res_d, out_q;
  logic             out_valid_q;

  // captured sample
  logic                        start_q;
  logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
  logic signed [HW_-1:0]       theta_q;
  logic signed [DEG_W-1:0]     deg_q;

  logic signed [POS_WIDTH-1:0] goal_x_q, goal_y_q;
  logic signed [HW_-1:0]       goal_h_q;
  logic signed [HW_-1:0]       goal_h_d;
  logic [ACC_W-1:0]            acc_q;

  logic in_ready, cordic_start, out_load;

  wttd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  // Goal heading: degrees to 1/8192 rad, rounded half away from zero, saturated.
  logic [DEG_W-1:0]  deg_mag;
  logic [32:0]       head_prod;
  logic [32:0]       head_rnd;
  logic [16:0]       head_mag;

  always_comb begin
    deg_mag   = deg_q[DEG_W-1] ? DEG_W'(-deg_q) : DEG_W'(deg_q);
    head_prod = {24'd0, deg_mag} * {9'd0, wttd_pkg::DEG_TO_Q13_Q16};
    head_rnd  = head_prod + 33'd32768;
    head_mag  = head_rnd[32:16];
    if (!deg_q[DEG_W-1]) begin
      goal_h_d = (head_mag > 17'd32767) ? 16'sh7FFF : $signed(head_mag[15:0]);
    end else begin
      goal_h_d = (head_mag > 17'd32768) ? 16'sh8000 : $signed(16'(-head_mag));
    end
  end

  // Turning phase evaluation.
  logic signed [HW_:0] err;
  logic [HW_:0]        aerr;
  logic                turn_done;
  logic [13:0]         err_cap;
  logic [MAG_W-1:0]    turn_sp;
  logic [MAG_W-1:0]    turn_mag;

  always_comb begin
    err       = $signed({theta_q[HW_-1], theta_q}) - $signed({goal_h_q[HW_-1], goal_h_q});
    aerr      = err[HW_] ? 17'(-err) : 17'(err);
    turn_done = aerr <= 17'(cfg.heading_tol);
    err_cap   = (aerr < 17'(wttd_pkg::TURN_CAP)) ? aerr[13:0] : wttd_pkg::TURN_CAP;
    turn_sp   = {err_cap, 1'b0};
    turn_mag  = (turn_sp < MAG_W'(cfg.turn_min)) ? MAG_W'(cfg.turn_min) : turn_sp;
  end

  // CORDIC operands: goal minus position with guard bits.
  logic signed [POS_WIDTH:0] dx, dy;
  logic signed [XW-1:0]      cx, cy;
  logic                      cordic_done;
  logic [XW-1:0]             cordic_x;
  logic signed [ZW-1:0]      cordic_z;

  assign dx = $signed({goal_x_q[POS_WIDTH-1], goal_x_q}) - $signed({pos_x_q[POS_WIDTH-1], pos_x_q});
  assign dy = $signed({goal_y_q[POS_WIDTH-1], goal_y_q}) - $signed({pos_y_q[POS_WIDTH-1], pos_y_q});
  assign cx = $signed({{(XW-POS_WIDTH-1-GUARD){dx[POS_WIDTH]}}, dx, {GUARD{1'b0}}});
  assign cy = $signed({{(XW-POS_WIDTH-1-GUARD){dy[POS_WIDTH]}}, dy, {GUARD{1'b0}}});

  wttd_cordic #(
    .XW         (XW),
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (cx),
    .y_i     (cy),
    .done_o  (cordic_done),
    .x_o     (cordic_x),
    .z_o     (cordic_z)
  );

  // Gain correction split in two partial products, on the low 16 bits and the upper bits of x.
  logic [31:0]   prod_lo;
  logic [XW-1:0] prod_hi;

  assign prod_lo = {16'd0, cordic_x[15:0]} * {16'd0, wttd_pkg::INV_GAIN_Q16};
  assign prod_hi = XW'(cordic_x[XW-1:16]) * XW'(wttd_pkg::INV_GAIN_Q16);

  // Driving phase evaluation.
  logic [ACC_W-1:0]        rnd1;
  logic [XW-1:0]           dist1;
  logic [XW-1:0]           rnd2;
  logic [DIST_W-1:0]       goal_dist;
  logic                    arrive;
  logic [LIN_W-1:0]        lin_hi;
  logic [LIN_W-1:0]        lin_cmd;
  logic signed [ZW-1:0]    z_rnd;
  logic signed [BRG_W-1:0] bearing;

  always_comb begin
    rnd1      = acc_q + ACC_W'(32768);
    dist1     = rnd1[ACC_W-1:16];
    rnd2      = dist1 + XW'(8);
    goal_dist = rnd2[XW-1:GUARD];
    arrive    = goal_dist <= DIST_W'(cfg.arrive_dist);
    lin_hi    = (goal_dist < DIST_W'(cfg.linear_max)) ? goal_dist[LIN_W-1:0] : cfg.linear_max;
    lin_cmd   = (lin_hi < cfg.linear_min) ? cfg.linear_min : lin_hi;
    z_rnd     = cordic_z + ZW'(4);
    bearing   = $signed(z_rnd[ZW-1:3]);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wttd_pkg::S_IDLE:   if (in_if.valid) state_d = wttd_pkg::S_GOAL;
      wttd_pkg::S_GOAL:   state_d = wttd_pkg::S_EVAL;
      wttd_pkg::S_EVAL: begin
        state_d = (phase_q == wttd_pkg::PH_DRIVE) ? wttd_pkg::S_CORDIC : wttd_pkg::S_HOLD;
      end
      wttd_pkg::S_CORDIC: if (cordic_done) state_d = wttd_pkg::S_MUL_LO;
      wttd_pkg::S_MUL_LO: state_d = wttd_pkg::S_MUL_HI;
      wttd_pkg::S_MUL_HI: state_d = wttd_pkg::S_DRIVE;
      wttd_pkg::S_DRIVE:  state_d = wttd_pkg::S_HOLD;
      wttd_pkg::S_HOLD:   if (!out_valid_q || out_if.ready) state_d = wttd_pkg::S_IDLE;
      default:            state_d = wttd_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready     = 1'b0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      wttd_pkg::S_IDLE: in_ready     = 1'b1;
      wttd_pkg::S_EVAL: cordic_start = (phase_q == wttd_pkg::PH_DRIVE);
      wttd_pkg::S_HOLD: out_load     = !out_valid_q || out_if.ready;
      default: begin
        in_ready     = 1'b0;
        cordic_start = 1'b0;
        out_load     = 1'b0;
      end
    endcase
  end

  // Phase update and result.
  always_comb begin
    phase_d = phase_q;
    res_d   = res_q;
    case (state_q)
      wttd_pkg::S_GOAL: if (start_q) phase_d = wttd_pkg::PH_TURN;
      wttd_pkg::S_EVAL: begin
        res_d.linear_cmd  = '0;
        res_d.angular_cmd = '0;
        res_d.arrived     = 1'b0;
        res_d.phase_out   = wttd_pkg::PH_IDLE;
        if (phase_q == wttd_pkg::PH_TURN) begin
          if (turn_done) begin
            phase_d         = wttd_pkg::PH_DRIVE;
            res_d.phase_out = wttd_pkg::PH_DRIVE;
          end else begin
            res_d.angular_cmd = wttd_pkg::signed_cmd(BRG_W'(goal_h_q), theta_q, turn_mag);
            res_d.phase_out   = wttd_pkg::PH_TURN;
          end
        end
      end
      wttd_pkg::S_DRIVE: begin
        res_d.linear_cmd  = '0;
        res_d.angular_cmd = '0;
        res_d.arrived     = 1'b0;
        if (arrive) begin
          phase_d         = wttd_pkg::PH_IDLE;
          res_d.arrived   = 1'b1;
          res_d.phase_out = wttd_pkg::PH_IDLE;
        end else begin
          res_d.linear_cmd  = lin_cmd;
          res_d.angular_cmd = wttd_pkg::signed_cmd(bearing, theta_q, MAG_W'(cfg.steer_rate));
          res_d.phase_out   = wttd_pkg::PH_DRIVE;
        end
      end
      default: begin
        phase_d = phase_q;
        res_d   = res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wttd_pkg::S_IDLE;
      phase_q     <= wttd_pkg::PH_IDLE;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      goal_h_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (state_q == wttd_pkg::S_GOAL && start_q) begin
        goal_x_q <= tgt_x_q;
        goal_y_q <= tgt_y_q;
        goal_h_q <= goal_h_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_ready && in_if.valid) begin
      start_q <= in_if.start_req;
      pos_x_q <= in_if.pos_x;
      pos_y_q <= in_if.pos_y;
      theta_q <= in_if.heading;
      tgt_x_q <= in_if.target_x;
      tgt_y_q <= in_if.target_y;
      deg_q   <= in_if.target_deg;
    end
    if (state_q == wttd_pkg::S_MUL_LO) begin
      acc_q <= ACC_W'(prod_lo);
    end else if (state_q == wttd_pkg::S_MUL_HI) begin
      acc_q <= acc_q + {prod_hi, 16'd0};
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid_q;
  assign out_if.linear_cmd  = out_q.linear_cmd;
  assign out_if.angular_cmd = out_q.angular_cmd;
  assign out_if.arrived     = out_q.arrived;
  assign out_if.phase_out   = out_q.phase_out;

endmodule

`default_nettype wire

// ===== rtl/wttd_cfg_regs.sv =====
// Configuration register bank written through the register channel.
`default_nettype none

module wttd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  wttd_cfg_if.sink      cfg_if,
  output wttd_pkg::cfg_t cfg_o
);

  wttd_pkg::cfg_t cfg_q;
  wttd_pkg::cfg_t cfg_d;

  assign cfg_if.ready = 1'b1;
  assign cfg_o        = cfg_q;

  // Keep the low bits of the data; ignore unknown indexes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        wttd_pkg::CFG_HEADING_TOL: cfg_d.heading_tol = cfg_if.data[12:0];
        wttd_pkg::CFG_ARRIVE_DIST: cfg_d.arrive_dist = cfg_if.data[11:0];
        wttd_pkg::CFG_LINEAR_MIN:  cfg_d.linear_min  = cfg_if.data[9:0];
        wttd_pkg::CFG_LINEAR_MAX:  cfg_d.linear_max  = cfg_if.data[9:0];
        wttd_pkg::CFG_STEER_RATE:  cfg_d.steer_rate  = cfg_if.data[13:0];
        wttd_pkg::CFG_TURN_MIN:    cfg_d.turn_min    = cfg_if.data[13:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heading_tol <= wttd_pkg::HEADING_TOL_RST;
      cfg_q.arrive_dist <= wttd_pkg::ARRIVE_DIST_RST;
      cfg_q.linear_min  <= wttd_pkg::LINEAR_MIN_RST;
      cfg_q.linear_max  <= wttd_pkg::LINEAR_MAX_RST;
      cfg_q.steer_rate  <= wttd_pkg::STEER_RATE_RST;
      cfg_q.turn_min    <= wttd_pkg::TURN_MIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wttd_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle through a shared adder set.
`default_nettype none

module wttd_cordic #(
  parameter int XW         = 23,
  parameter int ITERATIONS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [XW-1:0]              x_i,
  input  logic signed [XW-1:0]              y_i,
  output logic                              done_o,
  output logic [XW-1:0]                     x_o,
  output logic signed [wttd_pkg::ZW-1:0]    z_o
);

  localparam int ZW    = wttd_pkg::ZW;
  localparam int IW    = wttd_pkg::ATAN_IDX_W;
  localparam int AW    = wttd_pkg::ATAN_W;
  localparam int NSTEP = (ITERATIONS < wttd_pkg::ATAN_LEN) ? ITERATIONS : wttd_pkg::ATAN_LEN;
  localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic signed [XW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 last;

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atan_ext;

  assign last   = (cnt_q == CNT_W'(NSTEP - 1));
  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

  always_comb begin
    xs       = x_q >>> cnt_q;
    ys       = y_q >>> cnt_q;
    atan_ext = $signed({{(ZW-AW){1'b0}}, wttd_pkg::atan_q16(IW'(cnt_q))});
    if (start_i) begin
      // Fold the left half-plane over by pi first.
      if (x_i[XW-1]) begin
        x_d = -x_i;
        y_d = -y_i;
        z_d = y_i[XW-1] ? -wttd_pkg::PI_Q16 : wttd_pkg::PI_Q16;
      end else begin
        x_d = x_i;
        y_d = y_i;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (!y_q[XW-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_ext;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_ext;
      end
    end else begin
      x_d = x_q;
      y_d = y_q;
      z_d = z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

endmodule

`default_nettype wire
